// ===== src/bsag_pkg.sv =====
package bsag_pkg;

	localparam int MAX_RANK    = 8;
	localparam int EXTENT_BITS = 16;
	localparam int OFFSET_BITS = 32;

	localparam int IDX_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int CNT_W  = $clog2(MAX_RANK + 1);
	localparam int PROD_W = OFFSET_BITS + EXTENT_BITS;

	localparam int IN_EXT_W    = 16;
	localparam int OUT_OFF_W   = 32;
	localparam int IN_DATA_W   = 2 * IN_EXT_W;
	localparam int OUT_RAW_W   = 1 + 3 * OUT_OFF_W;
	localparam int OUT_DATA_W  = 8 * ((OUT_RAW_W + 7) / 8);
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_RAW_W;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_REWIND = 2'd2,
		OP_NEXT   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_BCAST = 3'd1,
		ST_TOO_MANY  = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_DONE      = 3'd4
	} status_t;

	typedef logic [1:0] err_t;

	localparam err_t ERR_NONE     = 2'd0;
	localparam err_t ERR_NOT_BCAST = 2'd1;
	localparam err_t ERR_TOO_MANY = 2'd2;
	localparam err_t ERR_OVERFLOW = 2'd3;

	typedef logic [EXTENT_BITS-1:0] ext_t;
	typedef logic [OFFSET_BITS-1:0] off_t;

endpackage

// ===== src/broadcast_stride_address_generator_top.sv =====
// Path: input register, one pass of logic, result register, then the master side.
// Throughput: one item per cycle while the master side does not stall (m_axis_tready).
// Each next item resolves its carry with a first-non-wrapping-dimension search over the
// plan and one add of a per-dimension step that is precomputed when the dimension is appended.
// Reset (arst_n low) empties the plan, rewinds the walk and clears the sticky error.
module broadcast_stride_address_generator_top
	import bsag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// left_extent, right_extent
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// valid_res, left_element_offset, right_element_offset, out_element_offset, zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// final_element
	output logic                  m_axis_tlast,
	// status
	output logic [2:0]            m_axis_tuser
);

	logic                 valid_s1;
	op_t                  op_s1;
	logic [IN_EXT_W-1:0]  left_ext_s1;
	logic [IN_EXT_W-1:0]  right_ext_s1;
	logic                 adv;

	ext_t                 dim_out_extent_q [MAX_RANK];
	off_t                 step_left_q [MAX_RANK];
	off_t                 step_right_q [MAX_RANK];
	ext_t                 dim_index_q [MAX_RANK];
	logic [CNT_W-1:0]     dim_count_q;
	off_t                 left_prod_q;
	off_t                 right_prod_q;
	off_t                 out_prod_q;
	off_t                 back_left_q;
	off_t                 back_right_q;
	off_t                 cur_left_q;
	off_t                 cur_right_q;
	off_t                 cur_out_q;
	err_t                 sticky_error_q;
	logic                 walk_done_q;

	logic                 out_valid_q;
	logic                 res_valid_q;
	logic [OUT_OFF_W-1:0] res_left_q;
	logic [OUT_OFF_W-1:0] res_right_q;
	logic [OUT_OFF_W-1:0] res_out_q;
	logic                 res_fin_q;
	status_t              res_status_q;

	ext_t                 le;
	ext_t                 re;
	ext_t                 oe;
	logic                 compat;
	logic [PROD_W-1:0]    prod_l;
	logic [PROD_W-1:0]    prod_r;
	logic [PROD_W-1:0]    prod_o;
	logic                 fits;
	logic                 bcast_l;
	logic                 bcast_r;
	off_t                 stride_l;
	off_t                 stride_r;
	logic [MAX_RANK-1:0]  wrap;
	logic                 found;
	logic [IDX_W-1:0]     k;

	logic                 do_clear;
	logic                 do_rewind;
	logic                 do_append;
	logic                 do_step;
	logic                 do_last;
	logic                 set_err;
	err_t                 new_err;

	logic                 res_valid;
	logic                 res_fin;
	status_t              res_status;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1        <= OP_CLEAR;
			left_ext_s1  <= '0;
			right_ext_s1 <= '0;
		end else if (s_axis_tready && s_axis_tvalid) begin
			op_s1        <= op_t'(s_axis_tuser);
			left_ext_s1  <= s_axis_tdata[IN_EXT_W-1:0];
			right_ext_s1 <= s_axis_tdata[IN_DATA_W-1:IN_EXT_W];
		end
	end

	always_comb begin
		le = EXTENT_BITS'(left_ext_s1);
		re = EXTENT_BITS'(right_ext_s1);
		compat = 1'b1;
		if (le == re) begin
			oe = le;
		end else if (le == EXTENT_BITS'(1)) begin
			oe = re;
		end else if (re == EXTENT_BITS'(1)) begin
			oe = le;
		end else begin
			oe = le;
			compat = 1'b0;
		end
		prod_l = PROD_W'(left_prod_q) * PROD_W'(le);
		prod_r = PROD_W'(right_prod_q) * PROD_W'(re);
		prod_o = PROD_W'(out_prod_q) * PROD_W'(oe);
		fits = (prod_l[PROD_W-1:OFFSET_BITS] == '0) && (prod_r[PROD_W-1:OFFSET_BITS] == '0)
			&& (prod_o[PROD_W-1:OFFSET_BITS] == '0);
		bcast_l  = (le == EXTENT_BITS'(1)) && (oe != EXTENT_BITS'(1));
		bcast_r  = (re == EXTENT_BITS'(1)) && (oe != EXTENT_BITS'(1));
		stride_l = bcast_l ? '0 : left_prod_q;
		stride_r = bcast_r ? '0 : right_prod_q;
	end

	always_comb begin
		found = 1'b0;
		k     = '0;
		for (int d = 0; d < MAX_RANK; d++) begin
			wrap[d] = (EXTENT_BITS'(dim_index_q[d] + EXTENT_BITS'(1)) == dim_out_extent_q[d]);
		end
		for (int d = MAX_RANK - 1; d >= 0; d--) begin
			if ((CNT_W'(d) < dim_count_q) && !wrap[d]) begin
				found = 1'b1;
				k     = IDX_W'(d);
			end
		end
	end

	always_comb begin
		do_clear   = 1'b0;
		do_rewind  = 1'b0;
		do_append  = 1'b0;
		do_step    = 1'b0;
		do_last    = 1'b0;
		set_err    = 1'b0;
		new_err    = ERR_NONE;
		res_valid  = 1'b0;
		res_fin    = 1'b0;
		res_status = ST_OK;
		unique case (op_s1)
			OP_CLEAR: begin
				do_clear = 1'b1;
			end
			OP_APPEND: begin
				if (sticky_error_q != ERR_NONE) begin
					res_status = status_t'({1'b0, sticky_error_q});
				end else if (dim_count_q >= CNT_W'(MAX_RANK)) begin
					set_err = 1'b1;
					new_err = ERR_TOO_MANY;
				end else if (!compat) begin
					set_err = 1'b1;
					new_err = ERR_NOT_BCAST;
				end else if (!fits) begin
					set_err = 1'b1;
					new_err = ERR_OVERFLOW;
				end else begin
					do_append = 1'b1;
					do_rewind = 1'b1;
				end
				if (set_err) begin
					res_status = status_t'({1'b0, new_err});
				end
			end
			OP_REWIND: begin
				do_rewind  = 1'b1;
				res_status = status_t'({1'b0, sticky_error_q});
			end
			OP_NEXT: begin
				if (sticky_error_q != ERR_NONE) begin
					res_status = status_t'({1'b0, sticky_error_q});
				end else if (walk_done_q || (out_prod_q == '0)) begin
					res_status = ST_DONE;
				end else begin
					res_valid = 1'b1;
					res_fin   = !found;
					do_step   = found;
					do_last   = !found;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q    <= '0;
			left_prod_q    <= OFFSET_BITS'(1);
			right_prod_q   <= OFFSET_BITS'(1);
			out_prod_q     <= OFFSET_BITS'(1);
			back_left_q    <= '0;
			back_right_q   <= '0;
			cur_left_q     <= '0;
			cur_right_q    <= '0;
			cur_out_q      <= '0;
			sticky_error_q <= ERR_NONE;
			walk_done_q    <= 1'b0;
			for (int d = 0; d < MAX_RANK; d++) begin
				dim_index_q[d] <= '0;
			end
		end else if (adv) begin
			if (do_clear) begin
				dim_count_q    <= '0;
				left_prod_q    <= OFFSET_BITS'(1);
				right_prod_q   <= OFFSET_BITS'(1);
				out_prod_q     <= OFFSET_BITS'(1);
				back_left_q    <= '0;
				back_right_q   <= '0;
				sticky_error_q <= ERR_NONE;
			end
			if (set_err) begin
				sticky_error_q <= new_err;
			end
			if (do_append) begin
				dim_count_q  <= dim_count_q + CNT_W'(1);
				left_prod_q  <= prod_l[OFFSET_BITS-1:0];
				right_prod_q <= prod_r[OFFSET_BITS-1:0];
				out_prod_q   <= prod_o[OFFSET_BITS-1:0];
				back_left_q  <= bcast_l ? back_left_q
					: back_left_q + prod_l[OFFSET_BITS-1:0] - left_prod_q;
				back_right_q <= bcast_r ? back_right_q
					: back_right_q + prod_r[OFFSET_BITS-1:0] - right_prod_q;
			end
			if (do_clear || do_rewind) begin
				cur_left_q  <= '0;
				cur_right_q <= '0;
				cur_out_q   <= '0;
				walk_done_q <= 1'b0;
				for (int d = 0; d < MAX_RANK; d++) begin
					dim_index_q[d] <= '0;
				end
			end
			if (do_step) begin
				cur_left_q  <= cur_left_q + step_left_q[k];
				cur_right_q <= cur_right_q + step_right_q[k];
				cur_out_q   <= cur_out_q + OFFSET_BITS'(1);
				for (int d = 0; d < MAX_RANK; d++) begin
					if (IDX_W'(d) == k) begin
						dim_index_q[d] <= EXTENT_BITS'(dim_index_q[d] + EXTENT_BITS'(1));
					end else if (IDX_W'(d) < k) begin
						dim_index_q[d] <= '0;
					end
				end
			end
			if (do_last) begin
				walk_done_q <= 1'b1;
				for (int d = 0; d < MAX_RANK; d++) begin
					if (CNT_W'(d) < dim_count_q) begin
						dim_index_q[d] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && do_append) begin
			dim_out_extent_q[dim_count_q[IDX_W-1:0]] <= oe;
			step_left_q[dim_count_q[IDX_W-1:0]]      <= stride_l - back_left_q;
			step_right_q[dim_count_q[IDX_W-1:0]]     <= stride_r - back_right_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_valid_q  <= res_valid;
			res_left_q   <= res_valid ? OUT_OFF_W'(cur_left_q) : '0;
			res_right_q  <= res_valid ? OUT_OFF_W'(cur_right_q) : '0;
			res_out_q    <= res_valid ? OUT_OFF_W'(cur_out_q) : '0;
			res_fin_q    <= res_fin;
			res_status_q <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_out_q, res_right_q, res_left_q, res_valid_q};
	assign m_axis_tlast  = res_fin_q;
	assign m_axis_tuser  = res_status_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		dim_count_q <= CNT_W'(MAX_RANK))
		else $error("plan holds more dimensions than the rank limit");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_error_q != ERR_NONE && !(adv && op_s1 == OP_CLEAR))
		|=> sticky_error_q == $past(sticky_error_q))
		else $error("sticky error changed without a clear");

	a_last_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_fin_q) |-> (res_valid_q && res_status_q == ST_OK))
		else $error("final element flagged on a result without offsets");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && do_last) |=> walk_done_q)
		else $error("walk not marked finished after its last element");
`endif

endmodule

// ===== dv/bsag_offset_checker.sv =====
module bsag_offset_checker
	import bsag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// left_extent, right_extent
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [1:0]            s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// valid_res, left_element_offset, right_element_offset, out_element_offset, zero fill
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	// final_element
	input  logic                  m_axis_tlast,
	// status
	input  logic [2:0]            m_axis_tuser,
	output int                    mismatch_count,
	output int                    offsets_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       valid;
		off_t       loff;
		off_t       roff;
		off_t       ooff;
		logic       fin;
		logic [2:0] st;
	} offset_item_t;

	localparam logic [63:0] OFF_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;

	ext_t        plan_ext     [MAX_RANK];
	off_t        plan_lstride [MAX_RANK];
	off_t        plan_rstride [MAX_RANK];
	ext_t        walk_idx     [MAX_RANK];
	int unsigned plan_dims;
	logic [63:0] lprod, rprod, oprod;
	off_t        walk_l, walk_r, walk_o;
	err_t        sticky;
	logic        walk_end;
	int          fails;

	offset_item_t expected_offsets[$];

	function automatic void rewind_walk();
		for (int d = 0; d < MAX_RANK; d++)
			walk_idx[d] = '0;
		walk_l = '0;
		walk_r = '0;
		walk_o = '0;
		walk_end = 1'b0;
	endfunction

	function automatic void clear_plan();
		for (int d = 0; d < MAX_RANK; d++) begin
			plan_ext[d] = '0;
			plan_lstride[d] = '0;
			plan_rstride[d] = '0;
		end
		plan_dims = 0;
		lprod = 64'd1;
		rprod = 64'd1;
		oprod = 64'd1;
		sticky = ERR_NONE;
		rewind_walk();
	endfunction

	function automatic logic fits(logic [63:0] p, logic [63:0] e);
		return (e == 64'd0) || (p * e <= OFF_LIMIT);
	endfunction

	function automatic offset_item_t predict_offsets(op_t op, ext_t le, ext_t re);
		offset_item_t r;
		err_t ae;
		ext_t oe;
		logic last;
		r = '0;
		case (op)
			OP_CLEAR: begin
				clear_plan();
			end
			OP_APPEND: begin
				ae = ERR_NONE;
				oe = '0;
				if (sticky != ERR_NONE)
					ae = sticky;
				else if (plan_dims >= MAX_RANK)
					ae = ERR_TOO_MANY;
				else begin
					if (le == re)
						oe = le;
					else if (le == ext_t'(1))
						oe = re;
					else if (re == ext_t'(1))
						oe = le;
					else
						ae = ERR_NOT_BCAST;
					if (ae == ERR_NONE && (!fits(lprod, 64'(le)) || !fits(rprod, 64'(re)) ||
							!fits(oprod, 64'(oe))))
						ae = ERR_OVERFLOW;
					if (ae == ERR_NONE) begin
						plan_ext[plan_dims] = oe;
						plan_lstride[plan_dims] = (le == ext_t'(1) && oe != ext_t'(1)) ?
							'0 : off_t'(lprod);
						plan_rstride[plan_dims] = (re == ext_t'(1) && oe != ext_t'(1)) ?
							'0 : off_t'(rprod);
						plan_dims++;
						lprod = lprod * 64'(le);
						rprod = rprod * 64'(re);
						oprod = oprod * 64'(oe);
						rewind_walk();
					end
				end
				if (ae != ERR_NONE)
					sticky = ae;
				r.st = {1'b0, ae};
			end
			OP_REWIND: begin
				rewind_walk();
				r.st = {1'b0, sticky};
			end
			default: begin
				if (sticky != ERR_NONE)
					r.st = {1'b0, sticky};
				else if (walk_end || oprod == 64'd0)
					r.st = ST_DONE;
				else begin
					r.valid = 1'b1;
					r.loff = walk_l;
					r.roff = walk_r;
					r.ooff = walk_o;
					last = 1'b1;
					for (int d = 0; d < plan_dims; d++)
						if (32'(walk_idx[d]) + 32'd1 != 32'(plan_ext[d]))
							last = 1'b0;
					r.fin = last;
					for (int d = 0; d < plan_dims; d++) begin
						walk_idx[d] = walk_idx[d] + 1'b1;
						walk_l = walk_l + plan_lstride[d];
						walk_r = walk_r + plan_rstride[d];
						if (d == 0)
							walk_o = walk_o + 1'b1;
						if (walk_idx[d] < plan_ext[d])
							break;
						walk_l = walk_l - walk_idx[d] * plan_lstride[d];
						walk_r = walk_r - walk_idx[d] * plan_rstride[d];
						walk_idx[d] = '0;
					end
					if (last)
						walk_end = 1'b1;
					else
						walk_o = r.ooff + 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		offset_item_t got, want;
		logic [OUT_PAD_W-1:0] fill;
		if (!arst_n) begin
			clear_plan();
			expected_offsets.delete();
			fails = 0;
			mismatch_count <= 0;
			offsets_outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.valid = m_axis_tdata[0];
				got.loff = m_axis_tdata[1 +: OUT_OFF_W];
				got.roff = m_axis_tdata[1 + OUT_OFF_W +: OUT_OFF_W];
				got.ooff = m_axis_tdata[1 + 2 * OUT_OFF_W +: OUT_OFF_W];
				got.fin = m_axis_tlast;
				got.st = m_axis_tuser;
				fill = m_axis_tdata[OUT_DATA_W-1:OUT_RAW_W];
				if (expected_offsets.size() == 0) begin
					if (fails < 10)
						$display("unexpected item: valid=%0b l=%h r=%h o=%h last=%0b st=%0d",
							got.valid, got.loff, got.roff, got.ooff, got.fin, got.st);
					fails++;
				end else begin
					want = expected_offsets.pop_front();
					if (got !== want || fill !== '0) begin
						if (fails < 10) begin
							$display("mismatch: exp valid=%0b l=%h r=%h o=%h last=%0b st=%0d",
								want.valid, want.loff, want.roff, want.ooff, want.fin,
								want.st);
							$display("          got valid=%0b l=%h r=%h o=%h last=%0b st=%0d fill=%h",
								got.valid, got.loff, got.roff, got.ooff, got.fin, got.st,
								fill);
						end
						fails++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_offsets.insert(expected_offsets.size(),
					predict_offsets(op_t'(s_axis_tuser), s_axis_tdata[IN_EXT_W-1:0],
					s_axis_tdata[2*IN_EXT_W-1:IN_EXT_W]));
			mismatch_count <= fails;
			offsets_outstanding <= expected_offsets.size();
		end
	end

endmodule

// ===== dv/tb_broadcast_stride_address_generator_top.sv =====
module tb_broadcast_stride_address_generator_top
	import bsag_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 3000;
	localparam int ITEM_TARGET = 1050;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic [2:0]            m_axis_tuser;

	int          mismatch_count;
	int          offsets_outstanding;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int          stall_cycles = 0;

	always #2 clk = ~clk;

	broadcast_stride_address_generator_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	bsag_offset_checker u_offset_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_axis_tvalid       (s_axis_tvalid),
		.s_axis_tready       (s_axis_tready),
		.s_axis_tdata        (s_axis_tdata),
		.s_axis_tuser        (s_axis_tuser),
		.m_axis_tvalid       (m_axis_tvalid),
		.m_axis_tready       (m_axis_tready),
		.m_axis_tdata        (m_axis_tdata),
		.m_axis_tlast        (m_axis_tlast),
		.m_axis_tuser        (m_axis_tuser),
		.mismatch_count      (mismatch_count),
		.offsets_outstanding (offsets_outstanding)
	);

	function automatic ext_t rand_ext();
		return ext_t'($urandom());
	endfunction

	task automatic send_item(input op_t op, input ext_t le, input ext_t re);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {re, le};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (offsets_outstanding != 0)
			@(posedge clk);
	endtask

	initial begin : rx_pattern
		int unsigned phase_left, mode, cyc, hold;
		phase_left = 0;
		mode = 0;
		cyc = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 600)
				hold = 300;
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 120);
			end
			phase_left--;
			if (hold != 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 9) < 7);
					2: m_axis_tready <= cyc[2];
					default: m_axis_tready <= ($urandom_range(0, 9) < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_broadcast_stride_address_generator_top: FAIL");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin : stimulus
		int unsigned seq_kind, ndim, span, nnext, pick, n;
		ext_t le, re, oe;
		logic drained_mid;
		drained_mid = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// scalar walk on an empty plan, then past its end
		send_item(OP_CLEAR, '0, '0);
		send_item(OP_NEXT, '0, '0);
		send_item(OP_NEXT, '1, '1);
		send_item(OP_REWIND, '0, '1);
		// 3 x 2 plan with a broadcast on each side, appended mid-walk
		send_item(OP_APPEND, ext_t'(3), ext_t'(1));
		send_item(OP_NEXT, '0, '0);
		send_item(OP_APPEND, ext_t'(1), ext_t'(2));
		repeat (7) send_item(OP_NEXT, '0, '0);
		// incompatible pair, sticky through next and rewind
		send_item(OP_APPEND, ext_t'(2), ext_t'(3));
		send_item(OP_NEXT, '0, '0);
		send_item(OP_REWIND, '0, '0);
		// largest extents, then size overflow
		send_item(OP_CLEAR, '1, '1);
		send_item(OP_APPEND, '1, '1);
		send_item(OP_APPEND, '1, ext_t'(1));
		send_item(OP_NEXT, '0, '0);
		send_item(OP_APPEND, ext_t'(2), ext_t'(1));
		// zero extent gives an empty output
		send_item(OP_CLEAR, '0, '0);
		send_item(OP_APPEND, '0, ext_t'(1));
		send_item(OP_NEXT, '0, '0);
		wait_drained();

		while (items_sent < ITEM_TARGET) begin
			if (!drained_mid && items_sent >= 600) begin
				wait_drained();
				drained_mid = 1'b1;
			end
			seq_kind = $urandom_range(0, 9);
			if (seq_kind <= 6) begin
				if ($urandom_range(0, 4) != 0)
					send_item(OP_CLEAR, rand_ext(), rand_ext());
				ndim = $urandom_range(0, 4);
				span = 1;
				for (int d = 0; d < ndim; d++) begin
					pick = $urandom_range(0, 19);
					if (pick == 0)
						oe = '0;
					else if (pick == 1)
						oe = ext_t'($urandom_range(256, 65535));
					else if (pick <= 4)
						oe = ext_t'(1);
					else
						oe = ext_t'($urandom_range(2, 5));
					case ($urandom_range(0, 2))
						0: begin
							le = oe;
							re = oe;
						end
						1: begin
							le = ext_t'(1);
							re = oe;
						end
						default: begin
							le = oe;
							re = ext_t'(1);
						end
					endcase
					send_item(OP_APPEND, le, re);
					span = (span * oe > 64) ? 64 : span * oe;
				end
				nnext = span + $urandom_range(0, 2);
				for (int i = 0; i < nnext; i++)
					if ($urandom_range(0, 24) == 0)
						send_item(OP_REWIND, rand_ext(), rand_ext());
					else
						send_item(OP_NEXT, rand_ext(), rand_ext());
			end else if (seq_kind == 7) begin
				send_item(OP_CLEAR, rand_ext(), rand_ext());
				for (int d = 0; d < MAX_RANK + 2; d++) begin
					le = ($urandom_range(0, 3) == 0) ? ext_t'(2) : ext_t'(1);
					re = ($urandom_range(0, 3) == 0) ? le : ext_t'(1);
					send_item(OP_APPEND, le, re);
				end
				nnext = $urandom_range(1, 8);
				repeat (nnext) send_item(OP_NEXT, rand_ext(), rand_ext());
			end else if (seq_kind == 8) begin
				send_item(OP_CLEAR, rand_ext(), rand_ext());
				send_item(OP_APPEND, ext_t'(2), ext_t'(2));
				case ($urandom_range(0, 2))
					0: send_item(OP_APPEND, rand_ext(), rand_ext());
					1: repeat (3) send_item(OP_APPEND, '1, '1);
					default: send_item(OP_APPEND, ext_t'(3), ext_t'(4));
				endcase
				nnext = $urandom_range(1, 4);
				repeat (nnext) send_item(OP_NEXT, rand_ext(), rand_ext());
				send_item(OP_REWIND, rand_ext(), rand_ext());
				send_item(OP_NEXT, rand_ext(), rand_ext());
			end else begin
				n = $urandom_range(1, 6);
				repeat (n) send_item(op_t'(2'($urandom_range(0, 3))), rand_ext(), rand_ext());
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && offsets_outstanding == 0)
			$display("tb_broadcast_stride_address_generator_top: PASS");
		else
			$display("tb_broadcast_stride_address_generator_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/bsag_pkg.sv
src/broadcast_stride_address_generator_top.sv
dv/bsag_offset_checker.sv
dv/tb_broadcast_stride_address_generator_top.sv
